### sv/ppbb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the ping-pong byte buffer.
package ppbb_pkg;

   // Buffer geometry
   localparam int BANK_BYTES = 256;
   localparam int MAX_READ   = 16;
   localparam int POS_W      = $clog2(BANK_BYTES);
   localparam int RPOS_W     = POS_W + 1;
   localparam int MEM_AW     = POS_W + 1;

   // Word field widths
   localparam int ACT_W  = 3;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 5;

   // Command queue between front and back
   localparam int CQ_DEPTH = 2;
   localparam int CQ_PTR_W = 1;
   localparam int CQ_CNT_W = 2;

   // Result queue
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OCNT_W    = 3;

   // Action codes on the request side
   localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
   localparam logic [ACT_W-1:0] ACT_READ  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FLUSH = 3'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
   localparam logic [ACT_W-1:0] ACT_KILL  = 3'd4;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_READ,
      OP_FLUSH,
      OP_CLEAR,
      OP_KILL,
      OP_NOP
   } cmd_op_type;

   typedef enum logic [2:0] {
      ST_WRITE,
      ST_FULL,
      ST_FLUSH,
      ST_FLUSHED,
      ST_FINISHED,
      ST_KILL
   } bstat_type;

   typedef enum logic [1:0] {
      CODE_OK,
      CODE_KILLED,
      CODE_NOT_READY,
      CODE_CLEAR_REFUSED
   } rsp_code_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_FLUSH
   } seq_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic              len_ok;
      logic              len_zero;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_out;
      logic              data_valid;
      logic              last;
      rsp_code_type      code;
      logic              accepted;
      logic              finished;
   } rsp_type;

   function automatic logic is_done(bstat_type s);
      return (s == ST_FINISHED) || (s == ST_KILL);
   endfunction

endpackage

### sv/ppbb_front.sv
`timescale 1ns / 1ps
// Front end: takes request words, decodes them and holds them in a short command queue.
module ppbb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [ppbb_pkg::ACT_W-1:0]    req_action,
   input  logic [ppbb_pkg::BYTE_W-1:0]   req_data_in,
   input  logic [ppbb_pkg::LEN_W-1:0]    req_read_len,
   output logic                          cmd_valid,
   output ppbb_pkg::cmd_type             cmd,
   input  logic                          cmd_pop
);
   import ppbb_pkg::*;

   cmd_type               q_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]   count_ff, count_in;
   cmd_type               dec;
   logic                  push_ok;
   logic                  pop_ok;

   // decode
   always_comb begin
      dec.data     = req_data_in;
      dec.len      = req_read_len;
      dec.len_ok   = (int'(req_read_len) <= MAX_READ) && (int'(req_read_len) <= BANK_BYTES);
      dec.len_zero = (req_read_len == '0);
      unique case (req_action)
         ACT_WRITE: dec.op = OP_WRITE;
         ACT_READ:  dec.op = OP_READ;
         ACT_FLUSH: dec.op = OP_FLUSH;
         ACT_CLEAR: dec.op = OP_CLEAR;
         ACT_KILL:  dec.op = OP_KILL;
         default:   dec.op = OP_NOP;
      endcase
   end

   assign req_full  = (count_ff == CQ_CNT_W'(CQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CQ_CNT_W'(push_ok) - CQ_CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

### sv/ppbb_back.sv
`timescale 1ns / 1ps
// Back end: bank memory, buffer status machine and the read / flush sequencer.
module ppbb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  ppbb_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   input  logic [ppbb_pkg::OCNT_W-1:0]   out_level,
   output logic                          out_push,
   output ppbb_pkg::rsp_type             out_word
);
   import ppbb_pkg::*;

   // architectural state
   bstat_type            status_ff, status_in;
   logic                 rbsel_ff, rbsel_in;
   logic [POS_W-1:0]     wpos_ff, wpos_in;
   logic [RPOS_W-1:0]    rpos_ff, rpos_in;

   // sequencer
   seq_type              seq_ff, seq_in;
   logic [LEN_W-1:0]     idx_ff, idx_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     can_ff, can_in;
   logic                 swap_ff, swap_in;
   logic [RPOS_W-1:0]    base_ff, base_in;
   logic                 obank_ff, obank_in;
   logic                 fin_ff, fin_in;
   logic [POS_W-1:0]     fill_ff, fill_in;

   // result stage
   logic                 resp_valid_ff, resp_valid_in;
   rsp_type              resp_ff, resp_in;
   logic                 resp_mem_ff, resp_mem_in;

   // bank memory
   logic [BYTE_W-1:0]    bank_mem_ff [2**MEM_AW];
   logic [BYTE_W-1:0]    rdata_ff;
   logic                 mem_we, mem_re;
   logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
   logic [BYTE_W-1:0]    mem_wdata;

   logic                 space;
   logic [RPOS_W-1:0]    avail;
   logic [LEN_W-1:0]     can;
   logic                 short_rd;
   logic [RPOS_W-1:0]    rd_sum;
   logic                 start_read, start_flush, seq_done;

   assign space = (out_level + OCNT_W'(resp_valid_ff)) < OCNT_W'(OUT_DEPTH);

   always_comb begin
      avail    = (rpos_ff < RPOS_W'(BANK_BYTES)) ? RPOS_W'(BANK_BYTES) - rpos_ff : '0;
      short_rd = avail < RPOS_W'(cmd.len);
      can      = short_rd ? LEN_W'(avail) : cmd.len;
      rd_sum   = base_ff + RPOS_W'(idx_ff);
   end

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (start_read) seq_in = SEQ_READ;
            else if (start_flush) seq_in = SEQ_FLUSH;
         end
         SEQ_READ: begin
            if (seq_done) seq_in = SEQ_IDLE;
         end
         SEQ_FLUSH: begin
            if (seq_done) seq_in = SEQ_IDLE;
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   // datapath and status updates
   always_comb begin
      status_in     = status_ff;
      rbsel_in      = rbsel_ff;
      wpos_in       = wpos_ff;
      rpos_in       = rpos_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      can_in        = can_ff;
      swap_in       = swap_ff;
      base_in       = base_ff;
      obank_in      = obank_ff;
      fin_in        = fin_ff;
      fill_in       = fill_ff;
      cmd_pop       = 1'b0;
      resp_valid_in = 1'b0;
      resp_mem_in   = 1'b0;
      resp_in.data_out   = '0;
      resp_in.data_valid = 1'b0;
      resp_in.last       = 1'b1;
      resp_in.code       = CODE_OK;
      resp_in.accepted   = 1'b0;
      resp_in.finished   = is_done(status_ff);
      mem_we        = 1'b0;
      mem_waddr     = {~rbsel_ff, wpos_ff};
      mem_wdata     = cmd.data;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      start_read    = 1'b0;
      start_flush   = 1'b0;
      seq_done      = 1'b0;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (cmd_valid && space) begin
               cmd_pop       = 1'b1;
               resp_valid_in = 1'b1;
               unique case (cmd.op)
                  OP_WRITE: begin
                     priority if (status_ff == ST_FLUSH) begin
                        status_in        = ST_WRITE;
                        resp_in.code     = CODE_NOT_READY;
                        resp_in.finished = 1'b0;
                     end else if (status_ff != ST_WRITE) begin
                        resp_in.code = (status_ff == ST_KILL) ? CODE_KILLED : CODE_NOT_READY;
                     end else begin
                        mem_we           = 1'b1;
                        resp_in.accepted = 1'b1;
                        resp_in.finished = 1'b0;
                        if (wpos_ff == POS_W'(BANK_BYTES - 1)) begin
                           status_in = ST_FULL;
                           wpos_in   = '0;
                        end else begin
                           wpos_in = wpos_ff + 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     priority if (status_ff == ST_KILL) begin
                        resp_in.code = CODE_KILLED;
                     end else if (!cmd.len_ok) begin
                        resp_in.code = CODE_NOT_READY;
                     end else if (cmd.len_zero) begin
                        resp_in.code = CODE_OK;
                     end else if (!short_rd ||
                                  status_ff == ST_FULL || status_ff == ST_FLUSH ||
                                  status_ff == ST_FLUSHED) begin
                        // streaming read; bytes follow from the sequencer
                        resp_valid_in = 1'b0;
                        start_read    = 1'b1;
                        idx_in        = '0;
                        len_in        = cmd.len;
                        can_in        = can;
                        base_in       = rpos_ff;
                        obank_in      = rbsel_ff;
                        swap_in       = 1'b0;
                        priority if (!short_rd) begin
                           rpos_in = rpos_ff + RPOS_W'(cmd.len);
                           fin_in  = is_done(status_ff);
                        end else if (status_ff == ST_FLUSHED) begin
                           status_in = ST_FINISHED;
                           fin_in    = 1'b1;
                        end else begin
                           swap_in   = 1'b1;
                           rbsel_in  = ~rbsel_ff;
                           status_in = (status_ff == ST_FLUSH) ? ST_FLUSHED : ST_WRITE;
                           rpos_in   = RPOS_W'(cmd.len - can);
                           fin_in    = 1'b0;
                        end
                     end else begin
                        resp_in.code = CODE_NOT_READY;
                     end
                  end
                  OP_FLUSH: begin
                     if (status_ff == ST_WRITE) begin
                        status_in        = ST_FLUSH;
                        fill_in          = wpos_ff;
                        start_flush      = 1'b1;
                        resp_in.finished = 1'b0;
                     end else begin
                        resp_in.code = (status_ff == ST_KILL) ? CODE_KILLED : CODE_OK;
                     end
                  end
                  OP_CLEAR: begin
                     rpos_in = RPOS_W'(BANK_BYTES);
                     if (status_ff == ST_FULL || status_ff == ST_FINISHED) begin
                        status_in        = ST_WRITE;
                        wpos_in          = '0;
                        resp_in.finished = 1'b0;
                     end else begin
                        resp_in.code = CODE_CLEAR_REFUSED;
                     end
                  end
                  OP_KILL: begin
                     status_in        = ST_KILL;
                     resp_in.finished = 1'b1;
                  end
                  default: begin
                     resp_in.code = CODE_OK;
                  end
               endcase
            end
         end
         SEQ_READ: begin
            if (space) begin
               resp_valid_in    = 1'b1;
               resp_in.finished = fin_ff;
               resp_in.last     = (idx_ff == len_ff - LEN_W'(1));
               priority if (idx_ff < can_ff) begin
                  mem_re             = 1'b1;
                  mem_raddr          = {obank_ff, rd_sum[POS_W-1:0]};
                  resp_mem_in        = 1'b1;
                  resp_in.data_valid = 1'b1;
               end else if (swap_ff) begin
                  mem_re             = 1'b1;
                  mem_raddr          = {~obank_ff, POS_W'(idx_ff - can_ff)};
                  resp_mem_in        = 1'b1;
                  resp_in.data_valid = 1'b1;
               end else begin
                  // zero padding past the end of a flushed bank
                  resp_in.data_valid = 1'b0;
               end
               idx_in   = idx_ff + 1'b1;
               seq_done = resp_in.last;
            end
         end
         SEQ_FLUSH: begin
            mem_we    = 1'b1;
            mem_waddr = {~rbsel_ff, fill_ff};
            mem_wdata = '0;
            fill_in   = fill_ff + 1'b1;
            seq_done  = (fill_ff == POS_W'(BANK_BYTES - 1));
         end
         default: begin
            seq_done = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= SEQ_IDLE;
         status_ff     <= ST_WRITE;
         rbsel_ff      <= 1'b0;
         wpos_ff       <= '0;
         rpos_ff       <= RPOS_W'(BANK_BYTES);
         resp_valid_ff <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         status_ff     <= status_in;
         rbsel_ff      <= rbsel_in;
         wpos_ff       <= wpos_in;
         rpos_ff       <= rpos_in;
         resp_valid_ff <= resp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      len_ff      <= len_in;
      can_ff      <= can_in;
      swap_ff     <= swap_in;
      base_ff     <= base_in;
      obank_ff    <= obank_in;
      fin_ff      <= fin_in;
      fill_ff     <= fill_in;
      resp_ff     <= resp_in;
      resp_mem_ff <= resp_mem_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bank_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= bank_mem_ff[mem_raddr];
      end
   end

   always_comb begin
      out_push = resp_valid_ff;
      out_word = resp_ff;
      if (resp_mem_ff) begin
         out_word.data_out = rdata_ff;
      end
   end

   a_flush_status: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_FLUSH) |-> (status_ff == ST_FLUSH))
      else $error("zero-fill running outside flush status");

   a_read_index: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_READ) |-> (idx_ff < len_ff))
      else $error("read index ran past requested length");

   a_rpos_range: assert property (@(posedge clock) disable iff (reset)
      rpos_ff <= RPOS_W'(BANK_BYTES))
      else $error("read position beyond bank");

endmodule

### sv/ppbb_out_fifo.sv
`timescale 1ns / 1ps
// Result queue: holds finished result words until the consumer pops them.
module ppbb_out_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ppbb_pkg::rsp_type             push_word,
   input  logic                          pop,
   output logic                          empty,
   output ppbb_pkg::rsp_type             head_word,
   output logic [ppbb_pkg::OCNT_W-1:0]   level
);
   import ppbb_pkg::*;

   rsp_type               q_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OCNT_W-1:0]     count_ff, count_in;
   logic                  pop_ok;

   assign empty     = (count_ff == '0);
   assign head_word = q_ff[rd_ptr_ff];
   assign level     = count_ff;
   assign pop_ok    = pop && !empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + OCNT_W'(push) - OCNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != OCNT_W'(OUT_DEPTH)))
      else $error("result queue overflow");

endmodule

### sv/ping_pong_byte_buffer_core.sv
`timescale 1ns / 1ps
// Top level of the ping-pong byte buffer.
// Two banks of BANK_BYTES bytes: the producer fills the write bank, the consumer reads the other.
// Request words (write, read, flush, clear, kill) go into a two-word command queue; req_full
// is high only when that queue is full, so a word can be pushed on every cycle while the back
// end has room. The back end runs one command at a time on a bank memory with one write port
// and one read port. Write, clear, kill, refused reads and a flush outside the write state are
// done in the step that takes the command. A read of N bytes has a start step, then sends one
// byte per cycle while the result queue has room, through the memory read port or as zero
// padding past the end of a flushed bank; a flush from the write state zero-fills the rest of
// the write bank one byte per cycle on the memory write port. Results land in a four-word
// result queue: a status word passes through the back end's result register and the result
// queue before it reaches the result ports; the first byte of a read comes after its start step.
// A stalled consumer holds off the back end; the front keeps taking words until its two-word
// queue fills.
// Every request yields one status word except a successful read of N >= 1 bytes, which
// yields N words; last marks the final word of each request. Bank bytes that were never
// written read back as undefined values.
module ping_pong_byte_buffer_core (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [ppbb_pkg::ACT_W-1:0]    req_action,
   input  logic [ppbb_pkg::BYTE_W-1:0]   req_data_in,
   input  logic [ppbb_pkg::LEN_W-1:0]    req_read_len,
   // result side
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ppbb_pkg::BYTE_W-1:0]   rsp_data_out,
   output logic                          rsp_data_valid,
   output logic                          rsp_last,
   output logic [1:0]                    rsp_code,
   output logic                          rsp_accepted,
   output logic                          rsp_finished
);
   import ppbb_pkg::*;

   logic               cmd_valid;
   cmd_type            cmd;
   logic               cmd_pop;
   logic [OCNT_W-1:0]  out_level;
   logic               out_push;
   rsp_type            out_word;
   rsp_type            head_word;

   // decode and queue requests
   ppbb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_action   (req_action),
      .req_data_in  (req_data_in),
      .req_read_len (req_read_len),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   // banks, status machine, read and flush sequencing
   ppbb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .out_level (out_level),
      .out_push  (out_push),
      .out_word  (out_word)
   );

   // result words wait here for the consumer
   ppbb_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_word (out_word),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head_word (head_word),
      .level     (out_level)
   );

   assign rsp_data_out   = head_word.data_out;
   assign rsp_data_valid = head_word.data_valid;
   assign rsp_last       = head_word.last;
   assign rsp_code       = head_word.code;
   assign rsp_accepted   = head_word.accepted;
   assign rsp_finished   = head_word.finished;

endmodule
